>>> sv/npod_pkg.sv
// Shared types and constants for the nearest point octant direction unit.
package npod_pkg;

  // Q16 scale and tan(22.5 deg) in Q16.
  localparam int unsigned Q16_SHIFT = 16;
  localparam int unsigned TAN_BITS = 15;
  localparam logic [TAN_BITS-1:0] TAN_Q16 = 15'd27146;

  typedef enum logic [3:0] {
    DIR_NONE       = 4'd0,
    DIR_UP         = 4'd1,
    DIR_DOWN       = 4'd2,
    DIR_LEFT       = 4'd3,
    DIR_RIGHT      = 4'd4,
    DIR_UP_LEFT    = 4'd5,
    DIR_UP_RIGHT   = 4'd6,
    DIR_DOWN_LEFT  = 4'd7,
    DIR_DOWN_RIGHT = 4'd8
  } dir_t;

  localparam logic [1:0] KIND_PLAYERS = 2'd1;

  // Classification of one queued item.
  typedef struct packed {
    logic list_empty;
    logic last_point;
    logic use_point;
  } item_ctl_t;

endpackage

>>> sv/npod_front.sv
// Front end: classifies an incoming item and computes its offset and squared distance.
module npod_front import npod_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic [1:0]              target_kind,
  input  logic [COORD_BITS-1:0]   query_x,
  input  logic [COORD_BITS-1:0]   query_y,
  input  logic [COORD_BITS-1:0]   point_x,
  input  logic [COORD_BITS-1:0]   point_y,
  input  logic                    is_self,
  input  logic                    list_empty,
  input  logic                    last_point,
  output item_ctl_t               ctl,
  output logic [2*COORD_BITS:0]   dist_sq,
  output logic signed [COORD_BITS:0] dx,
  output logic signed [COORD_BITS:0] dy
);

  logic [COORD_BITS:0]     neg_dx;
  logic [COORD_BITS:0]     neg_dy;
  logic [COORD_BITS-1:0]   ax;
  logic [COORD_BITS-1:0]   ay;
  logic [2*COORD_BITS-1:0] sq_x;
  logic [2*COORD_BITS-1:0] sq_y;

  always_comb begin
    dx = $signed({1'b0, point_x}) - $signed({1'b0, query_x});
    dy = $signed({1'b0, point_y}) - $signed({1'b0, query_y});
    neg_dx = -dx;
    neg_dy = -dy;
    ax = dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ay = dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    sq_x = ax * ax;
    sq_y = ay * ay;
    dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
    ctl.list_empty = list_empty;
    ctl.last_point = last_point;
    // Self entries drop out only when the query looks for players.
    ctl.use_point = !list_empty && !(target_kind == KIND_PLAYERS && is_self);
  end

endmodule

>>> sv/npod_queue.sv
// Small register FIFO that decouples the front end from the back end.
module npod_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/npod_back.sv
// Back end: keeps the nearest point of a query and turns its offset into a direction.
module npod_back import npod_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  item_ctl_t                  q_ctl,
  input  logic [2*COORD_BITS:0]      q_dist_sq,
  input  logic signed [COORD_BITS:0] q_dx,
  input  logic signed [COORD_BITS:0] q_dy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3:0]                 direction
);

  localparam int PW = COORD_BITS + Q16_SHIFT;

  // Running best of the open query.
  logic [2*COORD_BITS:0]      best_d;
  logic signed [COORD_BITS:0] best_dx;
  logic signed [COORD_BITS:0] best_dy;
  logic                       have_best;

  // Finished query waiting for its direction.
  logic                       b_valid;
  logic                       b_have;
  logic signed [COORD_BITS:0] b_dx;
  logic signed [COORD_BITS:0] b_dy;

  logic                       take;
  logic                       ending;
  logic                       out_space;
  logic                       b_fire;
  logic                       b_accept;
  logic signed [COORD_BITS:0] cur_dx;
  logic signed [COORD_BITS:0] cur_dy;

  logic [COORD_BITS:0]        neg_dx;
  logic [COORD_BITS:0]        neg_dy;
  logic [COORD_BITS-1:0]      ax;
  logic [COORD_BITS-1:0]      ay;
  logic [PW-1:0]              x_sc;
  logic [PW-1:0]              y_sc;
  logic [PW-1:0]              x_tn;
  logic [PW-1:0]              y_tn;
  logic                       dx_pos;
  logic                       dx_neg;
  logic                       dy_pos;
  logic                       dy_neg;
  dir_t                       dir;

  assign out_space = !out_valid || out_ready;
  assign b_fire    = b_valid && out_space;
  assign b_accept  = !b_valid || out_space;
  assign q_pop     = q_valid && b_accept;
  assign ending    = q_ctl.list_empty || q_ctl.last_point;
  assign take      = q_ctl.use_point && (!have_best || q_dist_sq < best_d);
  assign cur_dx    = take ? q_dx : best_dx;
  assign cur_dy    = take ? q_dy : best_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_d    <= '1;
      best_dx   <= '0;
      best_dy   <= '0;
      have_best <= 1'b0;
    end else if (q_pop) begin
      if (ending) begin
        best_d    <= '1;
        best_dx   <= '0;
        best_dy   <= '0;
        have_best <= 1'b0;
      end else if (take) begin
        best_d    <= q_dist_sq;
        best_dx   <= q_dx;
        best_dy   <= q_dy;
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (q_pop && ending) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && ending) begin
      b_have <= !q_ctl.list_empty && (have_best || take);
      b_dx   <= cur_dx;
      b_dy   <= cur_dy;
    end
  end

  // Sector borders: compare |dy|*65536 against |dx|*tan(22.5) and the converse.
  always_comb begin
    neg_dx = -b_dx;
    neg_dy = -b_dy;
    ax = b_dx[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : b_dx[COORD_BITS-1:0];
    ay = b_dy[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : b_dy[COORD_BITS-1:0];
    x_sc = {ax, {Q16_SHIFT{1'b0}}};
    y_sc = {ay, {Q16_SHIFT{1'b0}}};
    x_tn = PW'(ax) * PW'(TAN_Q16);
    y_tn = PW'(ay) * PW'(TAN_Q16);
    dx_neg = b_dx[COORD_BITS];
    dy_neg = b_dy[COORD_BITS];
    dx_pos = !dx_neg && (b_dx != '0);
    dy_pos = !dy_neg && (b_dy != '0);

    if (!b_have) begin
      dir = DIR_NONE;
    end else if (b_dx == '0 && b_dy == '0) begin
      dir = DIR_RIGHT;
    end else if (dx_pos && !dy_neg) begin
      if (y_sc < x_tn) dir = DIR_RIGHT;
      else if (x_sc <= y_tn) dir = DIR_DOWN;
      else dir = DIR_DOWN_RIGHT;
    end else if (!dx_pos && dy_pos) begin
      if (x_sc < y_tn) dir = DIR_DOWN;
      else if (y_sc <= x_tn) dir = DIR_LEFT;
      else dir = DIR_DOWN_LEFT;
    end else if (dx_neg && !dy_pos) begin
      if (y_sc < x_tn) dir = DIR_LEFT;
      else if (x_sc <= y_tn) dir = DIR_UP;
      else dir = DIR_UP_LEFT;
    end else begin
      if (x_sc < y_tn) dir = DIR_UP;
      else if (y_sc <= x_tn) dir = DIR_RIGHT;
      else dir = DIR_UP_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      direction <= dir;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (q_pop && ending) |=> (!have_best && best_d == '1))
    else $error("best state not cleared after an ending item");

  a_empty_best_is_max: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (best_d == '1 && best_dx == '0 && best_dy == '0))
    else $error("best state holds data without a kept point");

  a_no_pop_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (b_valid && out_valid && !out_ready) |-> !q_pop)
    else $error("queue popped while the finished stage is blocked");

  a_dir_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction <= DIR_DOWN_RIGHT))
    else $error("direction code out of range");

endmodule

>>> sv/nearest_point_octant_direction_unit.sv
// Top level of the nearest point octant direction unit.
// Throughput: one item per cycle while the output keeps up; the back end stops popping while the output stalls.
// The result of an ending item passes from the queue through the back end into the finished register,
// then into the direction register.
// The two-entry queue lets the input keep flowing while the output stalls briefly.
// Reset (rst, synchronous) empties the queue, clears the open query and drops out_valid.
module nearest_point_octant_direction_unit import npod_pkg::*; #(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            target_kind,
  input  logic [COORD_BITS-1:0] query_x,
  input  logic [COORD_BITS-1:0] query_y,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic                  is_self,
  input  logic                  list_empty,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            direction
);

  localparam int CTL_W   = $bits(item_ctl_t);
  localparam int DIST_W  = 2 * COORD_BITS + 1;
  localparam int OFF_W   = COORD_BITS + 1;
  localparam int ENTRY_W = CTL_W + DIST_W + 2 * OFF_W;

  item_ctl_t                  f_ctl;
  logic [DIST_W-1:0]          f_dist_sq;
  logic signed [OFF_W-1:0]    f_dx;
  logic signed [OFF_W-1:0]    f_dy;
  logic [ENTRY_W-1:0]         push_data;
  logic [ENTRY_W-1:0]         pop_data;
  logic                       q_full;
  logic                       q_valid;
  logic                       q_pop;
  item_ctl_t                  q_ctl;
  logic [DIST_W-1:0]          q_dist_sq;
  logic signed [OFF_W-1:0]    q_dx;
  logic signed [OFF_W-1:0]    q_dy;

  npod_front #(.COORD_BITS(COORD_BITS)) u_front (
    .target_kind (target_kind),
    .query_x     (query_x),
    .query_y     (query_y),
    .point_x     (point_x),
    .point_y     (point_y),
    .is_self     (is_self),
    .list_empty  (list_empty),
    .last_point  (last_point),
    .ctl         (f_ctl),
    .dist_sq     (f_dist_sq),
    .dx          (f_dx),
    .dy          (f_dy)
  );

  assign push_data = {f_ctl, f_dist_sq, f_dx, f_dy};
  assign in_ready  = !q_full;

  npod_queue #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  assign {q_ctl, q_dist_sq, q_dx, q_dy} = pop_data;

  npod_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_dist_sq (q_dist_sq),
    .q_dx      (q_dx),
    .q_dy      (q_dy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .direction (direction)
  );

endmodule
